[src/ahfd_pkg.sv]
// Shared types, constants and helpers for the ASCII hex frame line decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ahfd_pkg;

  localparam int FRAME_BYTES_DEF = 36;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;

  typedef struct packed {
    logic [7:0] char_code;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       frame_last;
  } out_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] ch);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (ch >= CH_0 && ch <= CH_9) begin
      h.val = 4'(ch - CH_0);
    end else if (ch >= CH_LA && ch <= CH_LF) begin
      h.val = 4'(ch - (CH_LA - 8'd10));
    end else if (ch >= CH_UA && ch <= CH_UF) begin
      h.val = 4'(ch - (CH_UA - 8'd10));
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

[src/ahfd_in_reg.sv]
// Input register stage: captures one character transfer and holds it for the core.
// Depends on ahfd_pkg.
`timescale 1ns / 1ps

module ahfd_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ahfd_pkg::in_t in_data,
  input  logic          take,
  output logic          full,
  output ahfd_pkg::in_t item
);

  logic          full_r, full_nxt;
  ahfd_pkg::in_t data_r;
  logic          load;

  assign in_stall = full_r && !take;
  assign load     = in_valid && !in_stall;
  assign full_nxt = load ? 1'b1 : (take ? 1'b0 : full_r);
  assign full     = full_r;
  assign item     = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

endmodule

[src/ahfd_core.sv]
// Line decoder state and result logic for one character per cycle while take is high.
// Depends on ahfd_pkg.
`timescale 1ns / 1ps

module ahfd_core #(
  parameter int FRAME_BYTES = ahfd_pkg::FRAME_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  ahfd_pkg::in_t  item,
  output logic           res_valid,
  output ahfd_pkg::out_t res
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);

  typedef enum logic [1:0] {
    PH_SKIP  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_DRAIN = 2'd3
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, cnt_inc;
  logic [3:0]         hi_nib_r, hi_nib_nxt;
  logic               hi_bad_r, hi_bad_nxt;
  ahfd_pkg::hex_t     hex;

  assign hex     = ahfd_pkg::hex_decode(item.char_code);
  assign cnt_inc = cnt_r + CNT_W'(1);

  always_comb begin
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    hi_nib_nxt     = hi_nib_r;
    hi_bad_nxt     = hi_bad_r;
    res_valid      = 1'b0;
    res.kind       = ahfd_pkg::KIND_BYTE;
    res.byte_value = 8'd0;
    res.frame_last = 1'b0;
    if (item.stream_end) begin
      res_valid  = 1'b1;
      res.kind   = (phase_r == PH_HIGH || phase_r == PH_LOW) ?
                   ahfd_pkg::KIND_BAD : ahfd_pkg::KIND_END;
      phase_nxt  = PH_SKIP;
      cnt_nxt    = '0;
      hi_nib_nxt = 4'd0;
      hi_bad_nxt = 1'b0;
    end else begin
      case (phase_r)
        PH_SKIP: begin
          if (item.char_code == ahfd_pkg::CH_COMMA) begin
            phase_nxt = PH_HIGH;
            cnt_nxt   = '0;
          end
        end
        PH_HIGH: begin
          hi_bad_nxt = !hex.ok;
          hi_nib_nxt = hex.ok ? hex.val : 4'd0;
          phase_nxt  = PH_LOW;
        end
        PH_LOW: begin
          res_valid  = 1'b1;
          hi_nib_nxt = 4'd0;
          hi_bad_nxt = 1'b0;
          if (!hex.ok || hi_bad_r) begin
            res.kind  = ahfd_pkg::KIND_BAD;
            phase_nxt = PH_SKIP;
            cnt_nxt   = '0;
          end else begin
            res.byte_value = {hi_nib_r, hex.val};
            if (cnt_inc == CNT_W'(FRAME_BYTES)) begin
              res.frame_last = 1'b1;
              phase_nxt      = PH_DRAIN;
              cnt_nxt        = '0;
            end else begin
              phase_nxt = PH_HIGH;
              cnt_nxt   = cnt_inc;
            end
          end
        end
        default: begin
          if (item.char_code == ahfd_pkg::CH_NEWLINE) begin
            phase_nxt  = PH_SKIP;
            cnt_nxt    = '0;
            hi_nib_nxt = 4'd0;
            hi_bad_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SKIP;
      cnt_r    <= '0;
      hi_nib_r <= 4'd0;
      hi_bad_r <= 1'b0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      hi_nib_r <= hi_nib_nxt;
      hi_bad_r <= hi_bad_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(FRAME_BYTES))
    else $error("byte count reached frame length");

  a_last_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.frame_last) |-> (res.kind == ahfd_pkg::KIND_BYTE &&
                                       phase_nxt == PH_DRAIN))
    else $error("frame end flagged without entering drain");

  a_end_to_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.stream_end) |=> (phase_r == PH_SKIP && cnt_r == '0))
    else $error("state not cleared after end of stream");
`endif

endmodule

[src/ahfd_out_buf.sv]
// Two-entry result buffer that decouples the result stall from the input side.
// Depends on ahfd_pkg.
`timescale 1ns / 1ps

module ahfd_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ahfd_pkg::out_t push_data,
  output logic           ready,
  output logic           out_valid,
  input  logic           out_stall,
  output ahfd_pkg::out_t out_data
);

  logic [1:0]     cnt_r, cnt_nxt;
  ahfd_pkg::out_t e0_r, e1_r;
  logic           pop;

  assign ready     = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = e0_r;
  assign pop       = out_valid && !out_stall;
  assign cnt_nxt   = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt_r == 2'd2) begin
        e0_r <= e1_r;
        if (push) begin
          e1_r <= push_data;
        end
      end else if (push) begin
        e0_r <= push_data;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        e0_r <= push_data;
      end else begin
        e1_r <= push_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'd2))
    else $error("push into full result buffer");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");
`endif

endmodule

[src/ascii_hex_frame_line_decoder.sv]
// Top level of the ASCII hex frame line decoder.
// Depends on ahfd_pkg, ahfd_in_reg, ahfd_core and ahfd_out_buf.
`timescale 1ns / 1ps

// Takes one character (or end-of-stream marker) per cycle and returns at most
// one result per character: a decoded frame byte, a clean end, or a malformed
// line. Throughput is one item per cycle while out_stall stays low. A result
// passes the input register, then the result buffer, before out_valid rises.
// The two-entry result buffer lets input keep flowing while one result waits.
module ascii_hex_frame_line_decoder #(
  parameter int FRAME_BYTES = ahfd_pkg::FRAME_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ahfd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ahfd_pkg::out_t out_data
);

  logic           full, take, buf_ready, res_valid;
  ahfd_pkg::in_t  item;
  ahfd_pkg::out_t res;

  assign take = full && buf_ready;

  ahfd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (take),
    .full     (full),
    .item     (item)
  );

  ahfd_core #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  ahfd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take && res_valid),
    .push_data (res),
    .ready     (buf_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
